// ===== rtl/voxel_neighbor_enumerator_26_core_assert.svh =====
// assertion helpers for the voxel neighbour enumerator
`ifndef VOXEL_NEIGHBOR_ENUMERATOR_26_CORE_ASSERT_SVH
`define VOXEL_NEIGHBOR_ENUMERATOR_26_CORE_ASSERT_SVH

// property that holds at every edge outside reset
`define VNE26_ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent now, consequent in the next cycle
`define VNE26_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vne26_pkg.sv =====
`default_nettype none

package vne26_pkg;

  localparam int unsigned IDX_W      = 24;
  localparam int unsigned REG_W      = 9;
  localparam int unsigned SLICE_W    = 2 * REG_W;
  localparam int unsigned TOTAL_W    = 3 * REG_W;
  localparam int unsigned CFG_AW     = 2;
  localparam int unsigned NUM_OFS    = 27;
  localparam int unsigned CENTRE_OFS = 13;

  localparam int unsigned DIM_BITS_DEF   = 8;
  localparam int unsigned FIFO_DEPTH_DEF = 2;

  localparam logic [REG_W-1:0] DIM_RESET = REG_W'(256);

  localparam logic [CFG_AW-1:0] REG_DIM_X = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_DIM_Y = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] REG_DIM_Z = CFG_AW'(2);

  typedef struct packed {
    logic [REG_W-1:0] dx;
    logic [REG_W-1:0] dy;
    logic [REG_W-1:0] dz;
  } dims_t;

  typedef struct packed {
    logic             oor;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] slice;
    logic [REG_W-1:0] px;
    logic [REG_W-1:0] py;
    logic [REG_W-1:0] pz;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/vne26_front.sv =====
`default_nettype none

module vne26_front import vne26_pkg::*; #(
  parameter int unsigned DIM_BITS = DIM_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dims_t            dims_i,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [IDX_W-1:0] voxel_index_i,
  input  wire logic             fifo_full_i,
  output logic                  fifo_push_o,
  output entry_t                fifo_entry_o
);

  localparam int unsigned MAXD_I = (DIM_BITS >= REG_W) ? ((1 << REG_W) - 1)
                                                       : (1 << DIM_BITS);
  localparam int unsigned QB     = $clog2(MAXD_I);
  localparam int unsigned CNTW   = $clog2(QB);
  localparam int unsigned DIVW0  = SLICE_W + QB - 1;
  localparam int unsigned CW     = (DIVW0 > IDX_W) ? DIVW0 : IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_CHECK,
    ST_DIV_Z,
    ST_DIV_Y,
    ST_PUSH
  } state_e;

  state_e             state_q;
  logic               buf_valid_q;
  logic [IDX_W-1:0]   buf_idx_q;
  logic [SLICE_W-1:0] slice_q;
  logic [TOTAL_W-1:0] total_q;
  logic [IDX_W-1:0]   rem_q;
  logic [CW-1:0]      div_q;
  logic [QB-1:0]      quo_q;
  logic [CNTW-1:0]    cnt_q;
  entry_t             entry_q;

  logic               ge;
  logic [IDX_W-1:0]   rem_nx;
  logic [QB-1:0]      quo_nx;

  assign full         = buf_valid_q;
  assign fifo_push_o  = (state_q == ST_PUSH) && !fifo_full_i;
  assign fifo_entry_o = entry_q;

  assign ge     = CW'(rem_q) >= div_q;
  assign rem_nx = ge ? (rem_q - div_q[IDX_W-1:0]) : rem_q;
  assign quo_nx = {quo_q[QB-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      buf_valid_q <= 1'b0;
    end else begin
      if (push && !buf_valid_q) begin
        buf_valid_q <= 1'b1;
        buf_idx_q   <= voxel_index_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (buf_valid_q) begin
            buf_valid_q   <= 1'b0;
            entry_q.idx   <= buf_idx_q;
            slice_q       <= {{REG_W{1'b0}}, dims_i.dx} * {{REG_W{1'b0}}, dims_i.dy};
            state_q       <= ST_TOTAL;
          end
        end
        ST_TOTAL: begin
          total_q       <= {{REG_W{1'b0}}, slice_q} * {{SLICE_W{1'b0}}, dims_i.dz};
          entry_q.slice <= IDX_W'(slice_q);
          state_q       <= ST_CHECK;
        end
        ST_CHECK: begin
          if ({{(TOTAL_W - IDX_W){1'b0}}, entry_q.idx} >= total_q) begin
            entry_q.oor <= 1'b1;
            entry_q.px  <= '0;
            entry_q.py  <= '0;
            entry_q.pz  <= '0;
            state_q     <= ST_PUSH;
          end else begin
            entry_q.oor <= 1'b0;
            rem_q       <= entry_q.idx;
            div_q       <= CW'(slice_q) << (QB - 1);
            cnt_q       <= CNTW'(QB - 1);
            state_q     <= ST_DIV_Z;
          end
        end
        ST_DIV_Z: begin
          rem_q <= rem_nx;
          quo_q <= quo_nx;
          if (cnt_q == '0) begin
            entry_q.pz <= REG_W'(quo_nx);
            div_q      <= CW'(dims_i.dx) << (QB - 1);
            cnt_q      <= CNTW'(QB - 1);
            state_q    <= ST_DIV_Y;
          end else begin
            div_q <= div_q >> 1;
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_DIV_Y: begin
          rem_q <= rem_nx;
          quo_q <= quo_nx;
          if (cnt_q == '0) begin
            entry_q.py <= REG_W'(quo_nx);
            entry_q.px <= rem_nx[REG_W-1:0];
            state_q    <= ST_PUSH;
          end else begin
            div_q <= div_q >> 1;
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_PUSH: begin
          if (!fifo_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vne26_fifo.sv =====
`default_nettype none

module vne26_fifo import vne26_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t wdata_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output entry_t      rdata_o,
  output logic        empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t          mem_q [DEPTH];
  logic [AW-1:0]   wptr_q;
  logic [AW-1:0]   rptr_q;
  logic [AW:0]     count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = count_q == (AW + 1)'(DEPTH);
  assign empty_o = count_q == '0;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vne26_back.sv =====
`default_nettype none

module vne26_back import vne26_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dims_t            dims_i,
  input  wire entry_t           entry_i,
  input  wire logic             fifo_empty_i,
  output logic                  fifo_pop_o,
  output logic                  empty,
  input  wire logic             pop,
  output logic [IDX_W-1:0]      neighbor_index_o,
  output logic                  valid_res_o,
  output logic                  out_of_range_o,
  output logic                  last_o
);

  logic               busy_q;
  logic [NUM_OFS-1:0] mask_q;
  logic               oor_q;
  logic [IDX_W-1:0]   idx_q;
  logic [IDX_W-1:0]   slice_q;
  logic               out_valid_q;

  logic [NUM_OFS-1:0] load_mask;
  logic [NUM_OFS-1:0] onehot;
  logic [NUM_OFS-1:0] rest;
  logic               out_ready;
  logic               emit;
  logic               done;
  logic               take;
  logic               xm, xp, ym, yp, zm, zp;
  logic [IDX_W-1:0]   dx_w;
  logic [IDX_W-1:0]   xoff, yoff, zoff;
  logic [IDX_W-1:0]   lin;

  // which of the three offsets along each axis stay inside the volume
  always_comb begin
    logic [2:0] vx, vy, vz;
    vx[0] = entry_i.px != '0;
    vx[1] = 1'b1;
    vx[2] = ({1'b0, entry_i.px} + 1'b1) < {1'b0, dims_i.dx};
    vy[0] = entry_i.py != '0;
    vy[1] = 1'b1;
    vy[2] = ({1'b0, entry_i.py} + 1'b1) < {1'b0, dims_i.dy};
    vz[0] = entry_i.pz != '0;
    vz[1] = 1'b1;
    vz[2] = ({1'b0, entry_i.pz} + 1'b1) < {1'b0, dims_i.dz};
    for (int z = 0; z < 3; z++) begin
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          load_mask[z*9 + y*3 + x] = vz[z] & vy[y] & vx[x];
        end
      end
    end
    load_mask[CENTRE_OFS] = 1'b0;
    if (entry_i.oor) begin
      load_mask = '0;
    end
  end

  assign onehot = mask_q & (~mask_q + 1'b1);
  assign rest   = mask_q & ~onehot;

  always_comb begin
    xm = 1'b0;
    xp = 1'b0;
    ym = 1'b0;
    yp = 1'b0;
    zm = 1'b0;
    zp = 1'b0;
    for (int z = 0; z < 3; z++) begin
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          if (x == 0) xm = xm | onehot[z*9 + y*3 + x];
          if (x == 2) xp = xp | onehot[z*9 + y*3 + x];
          if (y == 0) ym = ym | onehot[z*9 + y*3 + x];
          if (y == 2) yp = yp | onehot[z*9 + y*3 + x];
          if (z == 0) zm = zm | onehot[z*9 + y*3 + x];
          if (z == 2) zp = zp | onehot[z*9 + y*3 + x];
        end
      end
    end
  end

  assign dx_w = IDX_W'(dims_i.dx);
  assign xoff = xp ? IDX_W'(1) : (xm ? '1 : '0);
  assign yoff = yp ? dx_w : (ym ? (~dx_w + 1'b1) : '0);
  assign zoff = zp ? slice_q : (zm ? (~slice_q + 1'b1) : '0);
  assign lin  = idx_q + xoff + yoff + zoff;

  assign out_ready  = !out_valid_q || pop;
  assign emit       = busy_q && out_ready;
  assign done       = emit && (rest == '0);
  assign take       = !fifo_empty_i && (!busy_q || done);
  assign fifo_pop_o = take;
  assign empty      = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        busy_q  <= 1'b1;
        mask_q  <= load_mask;
        oor_q   <= entry_i.oor;
        idx_q   <= entry_i.idx;
        slice_q <= entry_i.slice;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        mask_q <= rest;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        if (mask_q == '0) begin
          neighbor_index_o <= '0;
          valid_res_o      <= 1'b0;
          out_of_range_o   <= oor_q;
          last_o           <= 1'b1;
        end else begin
          neighbor_index_o <= lin;
          valid_res_o      <= 1'b1;
          out_of_range_o   <= 1'b0;
          last_o           <= rest == '0;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/voxel_neighbor_enumerator_26_core.sv =====
// flow: the front buffers an accepted index, forms slice and volume, checks the range,
// then divides out z and y (Q quotient bits, 8 at default) unless the index is beyond
// the volume, and queues the entry; the back loads it and emits one result beat
// per cycle while the receiver pops; the one-bit-per-cycle divider paces in-range items
// reset: asynchronous, dimensions return to 256 and all queues are cleared to empty
`default_nettype none

module voxel_neighbor_enumerator_26_core import vne26_pkg::*; #(
  parameter int unsigned DIM_BITS   = DIM_BITS_DEF,
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_AW-1:0] cfg_addr_i,
  input  wire logic [REG_W-1:0]  cfg_wdata_i,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [IDX_W-1:0]  voxel_index_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic [IDX_W-1:0]       neighbor_index_o,
  output logic                   valid_res_o,
  output logic                   out_of_range_o,
  output logic                   last_o
);

  localparam int unsigned MAXD_I = (DIM_BITS >= REG_W) ? ((1 << REG_W) - 1)
                                                       : (1 << DIM_BITS);
  localparam logic [REG_W-1:0] MAXD = REG_W'(MAXD_I);

  logic [REG_W-1:0] dim_x_q, dim_y_q, dim_z_q;
  dims_t            dims;
  logic             fifo_push, fifo_full, fifo_pop, fifo_empty;
  entry_t           fifo_wdata, fifo_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q <= DIM_RESET;
      dim_y_q <= DIM_RESET;
      dim_z_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_DIM_X: dim_x_q <= cfg_wdata_i;
        REG_DIM_Y: dim_y_q <= cfg_wdata_i;
        REG_DIM_Z: dim_z_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign dims.dx = (dim_x_q > MAXD) ? MAXD : dim_x_q;
  assign dims.dy = (dim_y_q > MAXD) ? MAXD : dim_y_q;
  assign dims.dz = (dim_z_q > MAXD) ? MAXD : dim_z_q;

  vne26_front #(
    .DIM_BITS (DIM_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dims_i        (dims),
    .push          (push),
    .full          (full),
    .voxel_index_i (voxel_index_i),
    .fifo_full_i   (fifo_full),
    .fifo_push_o   (fifo_push),
    .fifo_entry_o  (fifo_wdata)
  );

  vne26_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (fifo_wdata),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .rdata_o (fifo_rdata),
    .empty_o (fifo_empty)
  );

  vne26_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .dims_i           (dims),
    .entry_i          (fifo_rdata),
    .fifo_empty_i     (fifo_empty),
    .fifo_pop_o       (fifo_pop),
    .empty            (empty),
    .pop              (pop),
    .neighbor_index_o (neighbor_index_o),
    .valid_res_o      (valid_res_o),
    .out_of_range_o   (out_of_range_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/vne26_checker.sv =====
`default_nettype none

`include "voxel_neighbor_enumerator_26_core_assert.svh"

module vne26_checker import vne26_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic [IDX_W-1:0]  neighbor_index_o,
  input wire logic              valid_res_o,
  input wire logic              out_of_range_o,
  input wire logic              last_o
);

  // a stalled result beat keeps its payload
  `VNE26_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(neighbor_index_o) && $stable(valid_res_o) && $stable(out_of_range_o) && $stable(last_o), "result beat changed while stalled")

  // a beat without a neighbour is the only beat of its item and carries index zero
  `VNE26_ASSERT_HOLDS(a_empty_beat, !empty && !valid_res_o |-> last_o && neighbor_index_o == '0, "beat without neighbour is not a lone final beat")

  // an index beyond the volume never yields a neighbour
  `VNE26_ASSERT_HOLDS(a_oor_no_neighbour, !empty && out_of_range_o |-> !valid_res_o, "out of range beat marked valid")

endmodule

bind voxel_neighbor_enumerator_26_core vne26_checker u_checker (.*);

`default_nettype wire

// ===== dv/voxel_neighbor_enumerator_26_core_tb.sv =====
module voxel_neighbor_enumerator_26_core_tb;
  import vne26_pkg::*;

  localparam logic [CFG_AW-1:0] REG_NONE = CFG_AW'(3);
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    logic [IDX_W-1:0] nidx;
    logic             valid;
    logic             oor;
    logic             last;
  } nbr_beat_t;

  class nbr_scoreboard;
    nbr_beat_t        expected_nbrs[$];
    logic [REG_W-1:0] dim_reg[3];
    int               fails;

    function new();
      dim_reg[0] = DIM_RESET;
      dim_reg[1] = DIM_RESET;
      dim_reg[2] = DIM_RESET;
      fails = 0;
    endfunction

    function void set_dim(logic [CFG_AW-1:0] addr, logic [REG_W-1:0] data);
      case (addr)
        REG_DIM_X: dim_reg[0] = data;
        REG_DIM_Y: dim_reg[1] = data;
        REG_DIM_Z: dim_reg[2] = data;
        default: ;
      endcase
    endfunction

    // register value saturated to the largest supported dimension
    function int span(int k);
      return (dim_reg[k] > 256) ? 256 : int'(dim_reg[k]);
    endfunction

    function int volume();
      return span(0) * span(1) * span(2);
    endfunction

    function int pending();
      return expected_nbrs.size();
    endfunction

    function void note_voxel(logic [IDX_W-1:0] vox);
      int        sx, sy, sz, slice, rem, lin;
      int        px, py, pz, nx, ny, nz, ox, oy, oz;
      nbr_beat_t found[$];
      sx = span(0);
      sy = span(1);
      sz = span(2);
      slice = sx * sy;
      if (int'(vox) >= volume()) begin
        expected_nbrs.push_back('{'0, 1'b0, 1'b1, 1'b1});
        return;
      end
      pz = int'(vox) / slice;
      rem = int'(vox) % slice;
      py = rem / sx;
      px = rem % sx;
      for (oz = -1; oz <= 1; oz++) begin
        nz = pz + oz;
        if (nz < 0 || nz >= sz) continue;
        for (oy = -1; oy <= 1; oy++) begin
          ny = py + oy;
          if (ny < 0 || ny >= sy) continue;
          for (ox = -1; ox <= 1; ox++) begin
            nx = px + ox;
            if (nx < 0 || nx >= sx) continue;
            if (ox == 0 && oy == 0 && oz == 0) continue;
            lin = nx + ny * sx + nz * slice;
            found.push_back('{IDX_W'(lin), 1'b1, 1'b0, 1'b0});
          end
        end
      end
      if (found.size() == 0) begin
        expected_nbrs.push_back('{'0, 1'b0, 1'b0, 1'b1});
      end else begin
        found[found.size()-1].last = 1'b1;
        foreach (found[i]) expected_nbrs.push_back(found[i]);
      end
    endfunction

    function void check_nbr(logic [IDX_W-1:0] nidx, logic valid, logic oor, logic last);
      nbr_beat_t e;
      if (expected_nbrs.size() == 0) begin
        $error("unexpected beat: neighbor_index %0d", nidx);
        fails++;
        return;
      end
      e = expected_nbrs.pop_front();
      if (nidx !== e.nidx) begin
        $error("neighbor_index: expected %0d, actual %0d", e.nidx, nidx);
        fails++;
      end
      if (valid !== e.valid) begin
        $error("valid_res: expected %0b, actual %0b", e.valid, valid);
        fails++;
      end
      if (oor !== e.oor) begin
        $error("out_of_range: expected %0b, actual %0b", e.oor, oor);
        fails++;
      end
      if (last !== e.last) begin
        $error("last: expected %0b, actual %0b", e.last, last);
        fails++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [REG_W-1:0]  cfg_wdata_i = '0;
  logic              push = 1'b0;
  logic              full;
  logic [IDX_W-1:0]  voxel_index_i = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [IDX_W-1:0]  neighbor_index_o;
  logic              valid_res_o;
  logic              out_of_range_o;
  logic              last_o;

  nbr_scoreboard sb = new();
  bit            gaps_on = 1'b1;
  int            hold_cycles = 0;
  int            pop_gap = 0;
  int            idle_cycles = 0;
  int            n_voxels = 0;
  int            n_beats = 0;
  int            n_volumes = 0;

  voxel_neighbor_enumerator_26_core i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .push,
    .full,
    .voxel_index_i,
    .empty,
    .pop,
    .neighbor_index_o,
    .valid_res_o,
    .out_of_range_o,
    .last_o
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      sb.check_nbr(neighbor_index_o, valid_res_o, out_of_range_o, last_o);
      n_beats++;
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_we_i) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // result side: long hold, random stall bursts, otherwise always ready
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        hold_cycles--;
      end else if (pop_gap > 0) begin
        pop <= 1'b0;
        pop_gap--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        pop_gap = $urandom_range(0, 7);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic feed_voxel(input logic [IDX_W-1:0] vox);
    push <= 1'b1;
    voxel_index_i <= vox;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_voxel(vox);
    n_voxels++;
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.pending() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [REG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_dim(addr, data);
    @(negedge clk_i);
  endtask

  task automatic set_volume(input logic [REG_W-1:0] x, y, z);
    wait_drained();
    cfg_write(REG_DIM_X, x);
    cfg_write(REG_DIM_Y, y);
    cfg_write(REG_DIM_Z, z);
    n_volumes++;
  endtask

  initial begin
    int               x, y, z, total, pick;
    logic [IDX_W-1:0] vox;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset dimensions 256 cubed
    feed_voxel('0);
    feed_voxel(24'hFFFFFF);
    feed_voxel(24'h808080);
    feed_voxel(24'h01FF00);

    set_volume(9'd3, 9'd3, 9'd3);
    feed_voxel(24'd13);
    feed_voxel(24'd0);
    feed_voxel(24'd26);
    feed_voxel(24'd27);
    feed_voxel(24'd4);

    // single voxel, no neighbours
    set_volume(9'd1, 9'd1, 9'd1);
    feed_voxel(24'd0);
    feed_voxel(24'd1);
    feed_voxel(24'hFFFFFF);

    // empty volume
    set_volume(9'd0, 9'd4, 9'd4);
    feed_voxel(24'd0);
    feed_voxel(24'd5);

    // oversize dimensions saturate, unmapped register ignored
    set_volume(9'd511, 9'd300, 9'd257);
    cfg_write(REG_NONE, '1);
    feed_voxel(24'hFFFFFF);
    feed_voxel(24'd0);
    feed_voxel(24'h7F7F7F);

    set_volume(9'd1, 9'd256, 9'd1);
    feed_voxel(24'd0);
    feed_voxel(24'd255);
    feed_voxel(24'd256);

    set_volume(9'd2, 9'd1, 9'd1);
    feed_voxel(24'd0);
    feed_voxel(24'd1);

    // receiver holds off while interior voxels keep coming
    set_volume(9'd8, 9'd8, 9'd8);
    hold_cycles = HOLD_CYCLES;
    repeat (20) begin
      vox = IDX_W'($urandom_range(1, 6) + 8 * $urandom_range(1, 6)
                   + 64 * $urandom_range(1, 6));
      feed_voxel(vox);
    end

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) gaps_on = 1'b0;
      x = $urandom_range(1, 6);
      y = $urandom_range(1, 6);
      z = $urandom_range(1, 6);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        case ($urandom_range(0, 2))
          0: x = 0;
          1: y = 0;
          default: z = 0;
        endcase
      end else if (pick == 1) begin
        x = $urandom_range(100, 511);
        y = $urandom_range(100, 511);
        z = $urandom_range(100, 511);
      end else if (pick == 2) begin
        x = $urandom_range(1, 256);
      end
      set_volume(REG_W'(x), REG_W'(y), REG_W'(z));
      total = sb.volume();
      repeat (20) begin
        pick = $urandom_range(0, 9);
        if (total > 0 && pick < 8) vox = IDX_W'($urandom_range(0, total - 1));
        else if (pick == 8) vox = IDX_W'(total + $urandom_range(0, 3));
        else vox = IDX_W'($urandom());
        feed_voxel(vox);
      end
    end

    wait_drained();
    $display("%0d voxel indices over %0d volume settings, %0d neighbour beats checked",
             n_voxels, n_volumes, n_beats);
    $display("covered edges, corners, empty, single-voxel, oversize and out-of-range cases");
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== voxel_neighbor_enumerator_26_core.f =====
+incdir+rtl
rtl/vne26_pkg.sv
rtl/vne26_front.sv
rtl/vne26_fifo.sv
rtl/vne26_back.sv
rtl/voxel_neighbor_enumerator_26_core.sv
rtl/vne26_checker.sv
dv/voxel_neighbor_enumerator_26_core_tb.sv
